>>> rtl/core/fgth_pkg.sv
package fgth_pkg;

  localparam int KID_SLOTS    = 4;   // kid genotypes that fit in one word
  localparam int MAX_KIDS_DEF = 4;
  localparam int CELLS        = 64;
  localparam int CELL_W       = 6;
  localparam int CNT_W        = 31;
  localparam int NK_W         = 3;
  localparam int GENO_W       = 2;
  localparam int S_TDATA_W    = 16;
  localparam int M_TDATA_W    = 72;

  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);

  typedef enum logic [0:0] {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // one load request for the output stage
  typedef struct packed {
    logic              load;
    logic              bad;
    logic [CELL_W-1:0] cidx;
    logic              last;
  } out_ctl_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

>>> rtl/core/fgth_ram.sv
module fgth_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/fgth_lane.sv
// One kid's trio histogram: read, saturating increment, write back.
module fgth_lane (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clr_en,
  input  logic [fgth_pkg::CELL_W-1:0] clr_addr,
  input  logic                     add_en,
  input  logic [fgth_pkg::CELL_W-1:0] add_addr,
  input  logic                     rd_en,
  input  logic [fgth_pkg::CELL_W-1:0] rd_addr,
  output logic [fgth_pkg::CNT_W-1:0]  rd_data
);
  import fgth_pkg::*;

  logic              s1_valid;
  logic [CELL_W-1:0] s1_addr;
  logic              fwd_valid;
  logic [CELL_W-1:0] fwd_addr;
  logic [CNT_W-1:0]  fwd_data;
  logic [CNT_W-1:0]  old_cnt;
  logic [CNT_W-1:0]  new_cnt;
  logic              we;
  logic [CELL_W-1:0] waddr;
  logic [CNT_W-1:0]  wdata;

  // the write from the previous cycle is not yet visible in the read data
  assign old_cnt = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : rd_data;
  assign new_cnt = sat_inc(old_cnt);

  assign we    = clr_en | s1_valid;
  assign waddr = clr_en ? clr_addr : s1_addr;
  assign wdata = clr_en ? '0 : new_cnt;

  fgth_ram #(
    .WIDTH (CNT_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (add_en | rd_en),
    .raddr (add_en ? add_addr : rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_valid  <= add_en;
      fwd_valid <= s1_valid;
    end
    s1_addr  <= add_addr;
    fwd_addr <= s1_addr;
    fwd_data <= new_cnt;
  end

endmodule

>>> rtl/core/fgth_merge.sv
// Output stage: picks the queried lane and holds the result word.
module fgth_merge #(
  parameter int LANES = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  fgth_pkg::out_ctl_t          ctl,
  input  logic [fgth_pkg::CNT_W-1:0]  lane_data [LANES],
  input  logic [1:0]                  kid_sel,
  input  logic [fgth_pkg::CNT_W-1:0]  total,
  output logic                        out_free,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [fgth_pkg::M_TDATA_W-1:0] m_tdata,  // cell_index, cell_count, total_records
  output logic                        m_tuser,  // bad_kid
  output logic                        m_tlast
);
  import fgth_pkg::*;

  logic [CNT_W-1:0] sel_cnt;

  always_comb begin
    sel_cnt = '0;
    for (int i = 0; i < LANES; i++) begin
      if (kid_sel == 2'(i)) begin
        sel_cnt = lane_data[i];
      end
    end
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (ctl.load) begin
      m_tdata <= {(M_TDATA_W - 2 * CNT_W - CELL_W)'(0), total,
                  ctl.bad ? CNT_W'(0) : sel_cnt, ctl.bad ? CELL_W'(0) : ctl.cidx};
      m_tuser <= ctl.bad;
      m_tlast <= ctl.last;
    end
  end

endmodule

>>> rtl/core/family_genotype_trio_histogram.sv
// Family genotype trio histogram.
// Input words (s_*): s_tuser is the op. An add word carries dad, mom and the
// packed kid genotypes; every kid lane in use bumps cell dad*16+mom*4+kid of
// its own 64-cell table, and the record total counts the word. A read word
// names a kid and returns its 64 cells in order on m_*, each with the record
// total, tlast on cell 63. A kid that is not in use gives a single word with
// tuser (bad_kid) and tlast set and zero cell and count.
// Config: cfg_data sets num_kids; cfg_ready is always high.
// Throughput: adds are taken every cycle while idle (read/increment/write per
// lane RAM, with a one-entry bypass for back-to-back hits on the same cell). A
// read holds s_tready low and emits its cells one at a time, each by a RAM read
// and then the output register; the next RAM read waits until the cell before
// is loaded. A stall on m_tready just holds the output register and the cell
// sequencer. A word for a kid that is not in use skips the RAM read and is
// loaded straight into the output register.
// Reset: a clearing pass writes zero to all 64 cells of every table, with
// s_tready low; config writes are still taken meanwhile. num_kids resets to 1.
module family_genotype_trio_histogram #(
  parameter int MAX_KIDS = fgth_pkg::MAX_KIDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fgth_pkg::S_TDATA_W-1:0]  s_tdata,  // dad_geno, mom_geno, kid_genos, kid_index
  input  logic                            s_tuser,  // op
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fgth_pkg::M_TDATA_W-1:0]  m_tdata,  // cell_index, cell_count, total_records
  output logic                            m_tuser,  // bad_kid
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fgth_pkg::NK_W-1:0]       cfg_data
);
  import fgth_pkg::*;

  localparam int LANES = (MAX_KIDS < KID_SLOTS) ? MAX_KIDS : KID_SLOTS;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_READ  = 3'b100
  } state_t;

  state_t            state;
  logic [NK_W-1:0]   num_kids;
  logic [NK_W-1:0]   lanes_used;
  logic [CNT_W-1:0]  record_total;
  logic [CELL_W-1:0] clr_addr;
  logic [CELL_W-1:0] rd_cell;
  logic              rd_pend;
  logic              rd_bad;
  logic [1:0]        rd_kid;
  logic              accept;
  logic              add_go;
  logic              rd_issue;
  logic              out_free;
  logic [1:0]        dad;
  logic [1:0]        mom;
  logic [7:0]        kids;
  logic [1:0]        kidx;
  out_ctl_t          ctl;
  logic [CNT_W-1:0]  lane_data [LANES];

  assign dad  = s_tdata[1:0];
  assign mom  = s_tdata[3:2];
  assign kids = s_tdata[11:4];
  assign kidx = s_tdata[13:12];

  assign cfg_ready  = 1'b1;
  assign lanes_used = (num_kids > NK_W'(LANES)) ? NK_W'(LANES) : num_kids;
  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign add_go     = accept && (s_tuser == OP_ADD);
  assign rd_issue   = (state == ST_READ) && !rd_bad && !rd_pend && out_free;

  always_comb begin
    ctl      = '0;
    ctl.bad  = rd_bad;
    ctl.cidx = rd_cell;
    if (state == ST_READ) begin
      if (rd_bad) begin
        ctl.load = out_free;
        ctl.last = 1'b1;
      end else begin
        ctl.load = rd_pend;
        ctl.last = (rd_cell == LAST_CELL);
      end
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    fgth_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .clr_en   (state == ST_CLEAR),
      .clr_addr (clr_addr),
      .add_en   (add_go && (NK_W'(i) < lanes_used)),
      .add_addr ({dad, mom, kids[2*i +: 2]}),
      .rd_en    (rd_issue),
      .rd_addr  (rd_cell),
      .rd_data  (lane_data[i])
    );
  end

  fgth_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .lane_data (lane_data),
    .kid_sel   (rd_kid),
    .total     (record_total),
    .out_free  (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      num_kids     <= NK_W'(1);
      record_total <= '0;
      clr_addr     <= '0;
      rd_cell      <= '0;
      rd_pend      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        num_kids <= cfg_data;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + CELL_W'(1);
          if (clr_addr == LAST_CELL) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (add_go) begin
            record_total <= sat_inc(record_total);
          end else if (accept) begin
            state   <= ST_READ;
            rd_cell <= '0;
            rd_pend <= 1'b0;
          end
        end
        ST_READ: begin
          if (rd_bad) begin
            if (out_free) begin
              state <= ST_IDLE;
            end
          end else if (rd_pend) begin
            rd_pend <= 1'b0;
            rd_cell <= rd_cell + CELL_W'(1);
            if (rd_cell == LAST_CELL) begin
              state <= ST_IDLE;
            end
          end else if (out_free) begin
            rd_pend <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_kid <= kidx;
      rd_bad <= ({1'b0, kidx} >= lanes_used);
    end
  end

endmodule

>>> rtl/core/fgth_checker.sv
module fgth_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [fgth_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tuser,
  input logic                           m_tlast
);
  import fgth_pkg::*;

  // tables are being cleared right after reset
  a_clear_blocks: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken during clearing pass");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && m_tdata[CELL_W+CNT_W-1:0] == '0)
    else $error("bad kid word not a lone zero word");

  // no input is taken in the middle of a table read
  a_busy_read: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready during table read");

endmodule

bind family_genotype_trio_histogram fgth_checker u_fgth_checker (.*);

>>> bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fgth_pkg::*;

  localparam int SETTLE_CYCLES = 8;       // add pipeline depth, generous
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    op_t              op;
    logic [GENO_W-1:0] dad;
    logic [GENO_W-1:0] mom;
    logic [7:0]        kids;
    logic [1:0]        kid_sel;
  } family_word_t;

  typedef struct packed {
    logic [CELL_W-1:0] cidx;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  total;
    logic              bad;
    logic              last;
  } cell_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = OP_ADD;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [NK_W-1:0]      cfg_data = '0;

  family_genotype_trio_histogram u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // predictor state
  logic [CNT_W-1:0] tally [KID_SLOTS][CELLS];
  logic [CNT_W-1:0] record_count;
  logic [NK_W-1:0]  kids_cfg = NK_W'(1);

  family_word_t family_words[$];
  cell_word_t   cells_due[$];
  int           fail_count = 0;
  int           cycle_count = 0;
  bit           idle_on = 1'b1;
  int           src_gap = 0;
  int           stall_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  function automatic int active_lanes();
    int n;
    n = kids_cfg;
    if (n > MAX_KIDS_DEF) n = MAX_KIDS_DEF;
    if (n > KID_SLOTS) n = KID_SLOTS;
    return n;
  endfunction

  // update the tables for an add word, or queue the cells a read returns
  task automatic apply_family_word(input logic op_bit, input logic [S_TDATA_W-1:0] d);
    logic [GENO_W-1:0] dad, mom;
    logic [7:0]        kids;
    logic [1:0]        sel;
    logic [CELL_W-1:0] idx;
    int                lanes;
    cell_word_t        w;
    dad   = d[1:0];
    mom   = d[3:2];
    kids  = d[11:4];
    sel   = d[13:12];
    lanes = active_lanes();
    if (op_t'(op_bit) == OP_ADD) begin
      for (int i = 0; i < lanes; i++) begin
        idx = {dad, mom, kids[2*i +: 2]};
        tally[i][idx] = bump_count(tally[i][idx]);
      end
      record_count = bump_count(record_count);
    end else if (sel >= lanes) begin
      w = '{cidx: '0, count: '0, total: record_count, bad: 1'b1, last: 1'b1};
      cells_due.insert(cells_due.size(), w);
    end else begin
      for (int c = 0; c < CELLS; c++) begin
        w.cidx  = CELL_W'(c);
        w.count = tally[sel][c];
        w.total = record_count;
        w.bad   = 1'b0;
        w.last  = (c == CELLS - 1);
        cells_due.insert(cells_due.size(), w);
      end
    end
  endtask

  task automatic check_cell_word();
    cell_word_t got, want;
    got.cidx  = m_tdata[5:0];
    got.count = m_tdata[36:6];
    got.total = m_tdata[67:37];
    got.bad   = m_tuser;
    got.last  = m_tlast;
    if (cells_due.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("unexpected word: cell %0d count %0d total %0d bad %0b last %0b",
                 got.cidx, got.count, got.total, got.bad, got.last);
    end else begin
      want = cells_due.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display({"mismatch: exp cell %0d count %0d total %0d bad %0b last %0b",
                    " / got cell %0d count %0d total %0d bad %0b last %0b"},
                   want.cidx, want.count, want.total, want.bad, want.last,
                   got.cidx, got.count, got.total, got.bad, got.last);
      end
    end
  endtask

  // sender
  always @(posedge clk) begin
    family_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= OP_ADD;
      src_gap = 0;
      record_count = '0;
      for (int k = 0; k < KID_SLOTS; k++)
        for (int c = 0; c < CELLS; c++)
          tally[k][c] = '0;
    end else begin
      if (s_tvalid && s_tready) apply_family_word(s_tuser, s_tdata);
      if (!s_tvalid || s_tready) begin
        if (src_gap != 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (family_words.size() != 0) begin
          w = family_words.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= w.op;
          s_tdata  <= {2'b00, w.kid_sel, w.kids, w.mom, w.dad};
          if (idle_on && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 13);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) check_cell_word();
      if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(0, 12);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic queue_add(input logic [1:0] dad, input logic [1:0] mom,
                           input logic [7:0] kids);
    family_word_t fw;
    fw = '{op: OP_ADD, dad: dad, mom: mom, kids: kids,
           kid_sel: 2'($urandom_range(0, 3))};
    family_words.insert(family_words.size(), fw);
  endtask

  task automatic queue_read(input logic [1:0] sel);
    family_word_t fw;
    fw = '{op: OP_READ, dad: 2'($urandom_range(0, 3)),
           mom: 2'($urandom_range(0, 3)),
           kids: 8'($urandom_range(0, 255)), kid_sel: sel};
    family_words.insert(family_words.size(), fw);
  endtask

  // wait until every queued word is taken and every read has drained
  task automatic drain();
    do @(negedge clk);
    while (family_words.size() != 0 || s_tvalid || cells_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_num_kids(input logic [NK_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    kids_cfg = v;
  endtask

  task automatic queue_random(input int n);
    logic [1:0] dad, mom, sel;
    logic [7:0] kids;
    int         lanes;
    dad  = 2'd0;
    mom  = 2'd0;
    kids = 8'd0;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 8) begin
        lanes = active_lanes();
        if (lanes == 0 || $urandom_range(0, 3) == 0) sel = 2'($urandom_range(0, 3));
        else sel = 2'($urandom_range(0, lanes - 1));
        queue_read(sel);
      end else begin
        // a quarter repeat the previous record to hit the same cells back to back
        if ($urandom_range(0, 3) != 0) begin
          dad  = 2'($urandom_range(0, 3));
          mom  = 2'($urandom_range(0, 3));
          kids = 8'($urandom_range(0, 255));
        end
        queue_add(dad, mom, kids);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // one lane after reset: empty table, out-of-range kids
    queue_read(2'd0);
    queue_read(2'd1);
    queue_read(2'd3);
    queue_add(2'd0, 2'd0, 8'h00);
    queue_add(2'd3, 2'd3, 8'hFF);
    queue_add(2'd3, 2'd3, 8'hFF);
    queue_add(2'd1, 2'd2, 8'hE4);
    queue_add(2'd2, 2'd1, 8'h1B);
    queue_read(2'd0);
    drain();

    write_num_kids(NK_W'(4));
    queue_add(2'd1, 2'd1, 8'hE4);
    queue_add(2'd3, 2'd0, 8'hB1);
    queue_add(2'd0, 2'd3, 8'h4E);
    queue_read(2'd0);
    queue_read(2'd1);
    queue_read(2'd2);
    queue_read(2'd3);
    drain();

    // no lanes: total still counts, every read is flagged
    write_num_kids(NK_W'(0));
    queue_add(2'd2, 2'd2, 8'h55);
    queue_read(2'd0);
    drain();

    write_num_kids(NK_W'(7));
    queue_add(2'd1, 2'd1, 8'hAA);
    queue_read(2'd3);
    queue_read(2'd2);
    drain();

    write_num_kids(NK_W'(2));
    queue_random(100);
    drain();

    write_num_kids(NK_W'(4));
    queue_random(50);
    drain();
    queue_random(50);
    drain();

    write_num_kids(NK_W'($urandom_range(0, 7)));
    queue_random(100);
    drain();

    idle_on = 1'b0;
    write_num_kids(NK_W'(3));
    queue_random(50);
    drain();
    idle_on = 1'b1;

    write_num_kids(NK_W'(1));
    queue_random(100);
    drain();

    idle_on = 1'b0;
    write_num_kids(NK_W'(4));
    queue_random(100);
    drain();

    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/fgth_pkg.sv
rtl/core/fgth_ram.sv
rtl/core/fgth_lane.sv
rtl/core/fgth_merge.sv
rtl/core/family_genotype_trio_histogram.sv
rtl/core/fgth_checker.sv
bench/testbench.sv
